// File: hdl/lpht_pkg.sv
// Package for the linear-probe hash table.
// Holds operation codes, slot status codes, controller states and the
// command/status structs shared by the controller and the datapath.
`default_nettype none

package lpht_pkg;

   localparam int KEY_W   = 64;
   localparam int DATA_W  = 64;
   localparam int LIMIT_W = 10;
   localparam int LIVE_W  = 11;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd767;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      SLOT_EMPTY   = 2'd0,
      SLOT_PRESENT = 2'd1,
      SLOT_TOMB    = 2'd2
   } slot_status_type;

   typedef struct packed {
      slot_status_type     status;
      logic [KEY_W-1:0]    key;
      logic [DATA_W-1:0]   data;
   } slot_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_PROBE,
      ST_SWEEP,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic probe;
      logic sweep;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic req_clear;
      logic probe_done;
      logic sweep_last;
   } stat_type;

endpackage

`default_nettype wire

// File: hdl/lpht_req_if.sv
// Request channel of the hash table: valid/ready handshake with mode, key
// and value. Depends on lpht_pkg for field widths.
`default_nettype none

interface lpht_req_if import lpht_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic [KEY_W-1:0]   key;
   logic [DATA_W-1:0]  value;

   modport source (output valid, output mode, output key, output value, input ready);
   modport sink   (input valid, input mode, input key, input value, output ready);
endinterface

`default_nettype wire

// File: hdl/lpht_rsp_if.sv
// Response channel of the hash table: valid/ready handshake with the
// result fields. Depends on lpht_pkg for field widths.
`default_nettype none

interface lpht_rsp_if import lpht_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               was_present;
   logic [DATA_W-1:0]  read_value;
   logic               refused;
   logic [LIVE_W-1:0]  live_entries;

   modport source (output valid, output was_present, output read_value,
                    output refused, output live_entries, input ready);
   modport sink   (input valid, input was_present, input read_value,
                   input refused, input live_entries, output ready);
endinterface

`default_nettype wire

// File: hdl/linear_probe_hash_table.sv
// Linear-probe hash table: 64-bit keys to 64-bit values in CAPACITY slots.
// Request channel req_chan carries mode (lookup, insert, remove, clear),
// key and value; response channel rsp_chan returns one item per request:
// was_present, read_value, refused and live_entries. csr_wr_en/csr_wr_data
// write the fill limit (reset 767); write it only while the table is idle.
// A request probes from the key's low bits upward, one slot per cycle, out
// of a single slot memory with registered read. The probe stops at a hit,
// an empty slot or after every slot; the finish step then loads the
// response register, and one more request can be accepted the cycle after
// the response is loaded. A clear sweeps every slot. After reset a sweep
// empties the table, with req_chan.ready low until it ends. A response
// waits in its output register while rsp_chan.ready is low; the next
// request is accepted and probed meanwhile and holds its finish step until
// the register is free.
// Depends on lpht_pkg, lpht_req_if, lpht_rsp_if, lpht_ctrl and lpht_dp.
`default_nettype none

module linear_probe_hash_table import lpht_pkg::*; #(
   parameter int CAPACITY = 1024
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic [LIMIT_W-1:0]  csr_wr_data,
   lpht_req_if.sink                 req_chan,
   lpht_rsp_if.source               rsp_chan
);

   cmd_type  cmd;
   stat_type stat;

   lpht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   lpht_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_mode         (req_chan.mode),
      .req_key          (req_chan.key),
      .req_value        (req_chan.value),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_was_present  (rsp_chan.was_present),
      .rsp_read_value   (rsp_chan.read_value),
      .rsp_refused      (rsp_chan.refused),
      .rsp_live_entries (rsp_chan.live_entries)
   );

`ifndef SYNTH
   a_init_sweep: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_chan.ready)
      else $error("request accepted before the init sweep");

   a_refused_new: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !(rsp_chan.refused && rsp_chan.was_present))
      else $error("refused item reported as present");

   a_value_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.read_value != '0)) |-> rsp_chan.was_present)
      else $error("read value without a hit");

   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.live_entries <= LIVE_W'(CAPACITY)))
      else $error("live count above capacity");
`endif

endmodule

`default_nettype wire

// File: hdl/lpht_ctrl.sv
// Controller state machine of the hash table: sequences init sweep, probe,
// clear sweep and finish, and owns the response valid flag. Uses lpht_pkg.
`default_nettype none

module lpht_ctrl import lpht_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire logic     rsp_ready,
   output logic          rsp_valid,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (stat.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = stat.req_clear ? ST_SWEEP : ST_PROBE;
         end
         ST_PROBE: begin
            if (stat.probe_done) state_in = ST_FINISH;
         end
         ST_SWEEP: begin
            if (stat.sweep_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_INIT: begin
            cmd.sweep = 1'b1;
         end
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_PROBE: begin
            cmd.probe = 1'b1;
         end
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
         end
         ST_FINISH: begin
            cmd.finish = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: hdl/lpht_dp.sv
// Datapath of the hash table: slot memory, probe walk, live count, fill
// limit register and response registers. Uses lpht_pkg.
`default_nettype none

module lpht_dp import lpht_pkg::*; #(
   parameter int CAPACITY = 1024
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic [LIMIT_W-1:0]  csr_wr_data,
   input  wire logic [1:0]          req_mode,
   input  wire logic [KEY_W-1:0]    req_key,
   input  wire logic [DATA_W-1:0]   req_value,
   input  wire cmd_type             cmd,
   output stat_type                 stat,
   output logic                     rsp_was_present,
   output logic [DATA_W-1:0]        rsp_read_value,
   output logic                     rsp_refused,
   output logic [LIVE_W-1:0]        rsp_live_entries
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

   slot_type            slot_mem_ff [CAPACITY];
   slot_type            rd_word_ff;
   logic [IDX_W-1:0]    rd_addr;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   slot_type            wr_word;

   op_type              mode_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [DATA_W-1:0]   value_ff;
   logic [IDX_W-1:0]    probe_idx_ff;
   logic [IDX_W-1:0]    probe_cnt_ff;
   logic                tomb_seen_ff;
   logic [IDX_W-1:0]    tomb_idx_ff;
   logic                found_ff;
   logic                free_ff;
   logic [IDX_W-1:0]    where_ff;
   logic [DATA_W-1:0]   found_data_ff;
   logic [IDX_W-1:0]    sweep_idx_ff;
   logic [LIVE_W-1:0]   live_ff, live_in;
   logic [LIMIT_W-1:0]  limit_ff;

   logic                rsp_present_ff, rsp_present_in;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                rsp_refused_ff, rsp_refused_in;
   logic [LIVE_W-1:0]   rsp_live_ff;

   logic                hit;
   logic                empty;
   logic                tomb_new;
   logic                last;
   logic                probe_done;

   assign hit   = (rd_word_ff.status == SLOT_PRESENT) && (rd_word_ff.key == key_ff);
   assign empty = (rd_word_ff.status == SLOT_EMPTY);
   assign tomb_new   = (rd_word_ff.status == SLOT_TOMB) && !tomb_seen_ff;
   assign last       = (probe_cnt_ff == LAST_IDX);
   assign probe_done = hit || empty || last;

   assign stat.req_clear  = (req_mode == OP_CLEAR);
   assign stat.probe_done = probe_done;
   assign stat.sweep_last = (sweep_idx_ff == LAST_IDX);

   // read the home slot at accept, then one slot ahead while probing
   always_comb begin
      if (cmd.accept) begin
         rd_addr = req_key[IDX_W-1:0];
      end else if (cmd.probe) begin
         rd_addr = probe_idx_ff + 1'b1;
      end else begin
         rd_addr = probe_idx_ff;
      end
   end

   always_comb begin
      wr_en          = 1'b0;
      wr_addr        = where_ff;
      wr_word        = '{status: SLOT_PRESENT, key: key_ff, data: value_ff};
      live_in        = live_ff;
      rsp_present_in = 1'b0;
      rsp_data_in    = '0;
      rsp_refused_in = 1'b0;
      if (cmd.sweep) begin
         wr_en          = 1'b1;
         wr_addr        = sweep_idx_ff;
         wr_word.status = SLOT_EMPTY;
      end else if (cmd.finish) begin
         case (mode_ff)
            OP_LOOKUP: begin
               rsp_present_in = found_ff;
               rsp_data_in    = found_ff ? found_data_ff : '0;
            end
            OP_INSERT: begin
               if (found_ff) begin
                  rsp_present_in = 1'b1;
                  wr_en          = 1'b1;
               end else if ((live_ff >= {1'b0, limit_ff}) || !free_ff) begin
                  rsp_refused_in = 1'b1;
               end else begin
                  wr_en   = 1'b1;
                  live_in = live_ff + 1'b1;
               end
            end
            OP_REMOVE: begin
               if (found_ff) begin
                  rsp_present_in = 1'b1;
                  wr_en          = 1'b1;
                  wr_word.status = SLOT_TOMB;
                  live_in        = live_ff - 1'b1;
               end
            end
            OP_CLEAR: begin
               live_in = '0;
            end
            default: begin
               live_in = live_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_word;
      end
      rd_word_ff <= slot_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff      <= op_type'(req_mode);
         key_ff       <= req_key;
         value_ff     <= req_value;
         probe_idx_ff <= req_key[IDX_W-1:0];
         probe_cnt_ff <= '0;
         tomb_seen_ff <= 1'b0;
      end else if (cmd.probe) begin
         probe_idx_ff <= probe_idx_ff + 1'b1;
         probe_cnt_ff <= probe_cnt_ff + 1'b1;
         if (tomb_new) begin
            tomb_seen_ff <= 1'b1;
            tomb_idx_ff  <= probe_idx_ff;
         end
         if (probe_done) begin
            found_ff      <= hit;
            free_ff       <= empty || tomb_seen_ff || tomb_new;
            where_ff      <= (!hit && tomb_seen_ff) ? tomb_idx_ff : probe_idx_ff;
            found_data_ff <= rd_word_ff.data;
         end
      end
      if (cmd.finish) begin
         rsp_present_ff <= rsp_present_in;
         rsp_data_ff    <= rsp_data_in;
         rsp_refused_ff <= rsp_refused_in;
         rsp_live_ff    <= live_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff      <= '0;
         limit_ff     <= LIMIT_RESET;
         sweep_idx_ff <= '0;
      end else begin
         live_ff <= live_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (cmd.sweep) begin
            sweep_idx_ff <= sweep_idx_ff + 1'b1;
         end
      end
   end

   assign rsp_was_present  = rsp_present_ff;
   assign rsp_read_value   = rsp_data_ff;
   assign rsp_refused      = rsp_refused_ff;
   assign rsp_live_entries = rsp_live_ff;

endmodule

`default_nettype wire

// File: verif/linear_probe_hash_table_tb.sv
// Self-checking testbench for linear_probe_hash_table: a directed table, then
// random request mixes and table-filling runs, each reply checked in order.
// Depends on lpht_pkg, lpht_req_if, lpht_rsp_if and the hash table RTL.
module linear_probe_hash_table_tb;
   import lpht_pkg::*;

   localparam int CAPACITY  = 1024;
   localparam int SLOT_BITS = 10;
   localparam int WATCHDOG  = 10000;
   localparam int TAIL      = CAPACITY + 16;
   localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic               was_present;
      logic [DATA_W-1:0]  read_value;
      logic               refused;
      logic [LIVE_W-1:0]  live_entries;
   } reply_type;

   typedef struct packed {
      logic               is_cfg;
      op_type             mode;
      logic [KEY_W-1:0]   key;
      logic [DATA_W-1:0]  value;
      logic               typed;
      reply_type          want;
   } step_type;

   localparam reply_type NONE = '{1'b0, 64'h0, 1'b0, 11'd0};

   localparam step_type DIRECTED [26] = '{
      '{1'b0, OP_LOOKUP, 64'h0, 64'h0, 1'b1, NONE},
      '{1'b0, OP_REMOVE, 64'h5, 64'h0, 1'b1, NONE},
      '{1'b0, OP_INSERT, 64'h0, ONES, 1'b1, '{1'b0, 64'h0, 1'b0, 11'd1}},
      '{1'b0, OP_INSERT, ONES, 64'h0, 1'b1, '{1'b0, 64'h0, 1'b0, 11'd2}},
      '{1'b0, OP_LOOKUP, 64'h0, 64'h0, 1'b1, '{1'b1, ONES, 1'b0, 11'd2}},
      '{1'b0, OP_LOOKUP, ONES, ONES, 1'b1, '{1'b1, 64'h0, 1'b0, 11'd2}},
      '{1'b0, OP_INSERT, 64'h400, 64'hA5A5_A5A5_A5A5_A5A5, 1'b0, NONE},
      '{1'b0, OP_INSERT, 64'h800, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0, NONE},
      '{1'b0, OP_REMOVE, 64'h400, 64'h0, 1'b0, NONE},
      '{1'b0, OP_LOOKUP, 64'h800, 64'h0, 1'b0, NONE},
      '{1'b0, OP_INSERT, 64'hC00, 64'h0123_4567_89AB_CDEF, 1'b0, NONE},
      '{1'b0, OP_INSERT, 64'h800, 64'h0F0F_0F0F_0F0F_0F0F, 1'b0, NONE},
      '{1'b0, OP_INSERT, 64'h7FF, 64'h7, 1'b0, NONE},
      '{1'b0, OP_LOOKUP, 64'h7FF, 64'h0, 1'b0, NONE},
      '{1'b0, OP_REMOVE, ONES, 64'h0, 1'b0, NONE},
      '{1'b0, OP_LOOKUP, 64'h7FF, 64'h0, 1'b0, NONE},
      '{1'b0, OP_CLEAR, ONES, ONES, 1'b1, NONE},
      '{1'b0, OP_LOOKUP, 64'h7FF, 64'h0, 1'b1, NONE},
      '{1'b1, OP_LOOKUP, 64'h0, 64'h1, 1'b0, NONE},
      '{1'b0, OP_INSERT, 64'h123, 64'h1, 1'b1, '{1'b0, 64'h0, 1'b0, 11'd1}},
      '{1'b0, OP_INSERT, 64'h456, 64'h2, 1'b1, '{1'b0, 64'h0, 1'b1, 11'd1}},
      '{1'b0, OP_INSERT, 64'h123, 64'h3, 1'b1, '{1'b1, 64'h0, 1'b0, 11'd1}},
      '{1'b0, OP_REMOVE, 64'h123, 64'h0, 1'b1, '{1'b1, 64'h0, 1'b0, 11'd0}},
      '{1'b1, OP_LOOKUP, 64'h0, 64'h0, 1'b0, NONE},
      '{1'b0, OP_INSERT, 64'h9, ONES, 1'b1, '{1'b0, 64'h0, 1'b1, 11'd0}},
      '{1'b0, OP_LOOKUP, 64'h456, 64'h0, 1'b1, NONE}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                csr_wr_en;
   logic [LIMIT_W-1:0]  csr_wr_data;

   lpht_req_if req_bus ();
   lpht_rsp_if rsp_bus ();

   linear_probe_hash_table #(.CAPACITY(CAPACITY)) DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus)
   );

   always #5 clock = ~clock;

   slot_status_type     map_status [CAPACITY];
   logic [KEY_W-1:0]    map_key    [CAPACITY];
   logic [DATA_W-1:0]   map_data   [CAPACITY];
   logic [LIVE_W-1:0]   map_live;
   logic [LIMIT_W-1:0]  map_limit;

   reply_type           pending_replies [$];
   logic [KEY_W-1:0]    filled_keys [$];
   int                  mismatches = 0;
   int                  replies_seen = 0;
   int                  quiet_cycles = 0;
   int                  src_calm = 0;
   int                  snk_calm = 0;

   function automatic logic locate(input logic [KEY_W-1:0] k, output int where,
                                   output logic have_free);
      int   idx;
      int   tomb_idx;
      logic tomb_seen;
      idx       = int'(k[SLOT_BITS-1:0]);
      tomb_idx  = 0;
      tomb_seen = 1'b0;
      have_free = 1'b0;
      where     = 0;
      for (int n = 0; n < CAPACITY; n++) begin
         if (map_status[idx] == SLOT_PRESENT && map_key[idx] == k) begin
            where = idx;
            return 1'b1;
         end
         if (map_status[idx] == SLOT_TOMB && !tomb_seen) begin
            tomb_seen = 1'b1;
            tomb_idx  = idx;
         end else if (map_status[idx] == SLOT_EMPTY) begin
            have_free = 1'b1;
            where     = tomb_seen ? tomb_idx : idx;
            return 1'b0;
         end
         idx = (idx + 1) % CAPACITY;
      end
      if (tomb_seen) begin
         have_free = 1'b1;
         where     = tomb_idx;
      end
      return 1'b0;
   endfunction

   function automatic reply_type hash_apply(input op_type m, input logic [KEY_W-1:0] k,
                                            input logic [DATA_W-1:0] v);
      reply_type r;
      int        where;
      logic      have_free;
      logic      hit;
      r = '0;
      case (m)
         OP_LOOKUP: begin
            if (locate(k, where, have_free)) begin
               r.was_present = 1'b1;
               r.read_value  = map_data[where];
            end
         end
         OP_INSERT: begin
            hit = locate(k, where, have_free);
            if (hit) begin
               r.was_present   = 1'b1;
               map_data[where] = v;
            end else if (map_live >= {1'b0, map_limit} || !have_free) begin
               r.refused = 1'b1;
            end else begin
               map_status[where] = SLOT_PRESENT;
               map_key[where]    = k;
               map_data[where]   = v;
               map_live          = map_live + 1'b1;
            end
         end
         OP_REMOVE: begin
            if (locate(k, where, have_free)) begin
               r.was_present     = 1'b1;
               map_status[where] = SLOT_TOMB;
               map_live          = map_live - 1'b1;
            end
         end
         default: begin
            foreach (map_status[i]) map_status[i] = SLOT_EMPTY;
            map_live = '0;
         end
      endcase
      r.live_entries = map_live;
      return r;
   endfunction

   function automatic int draw_idle(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      return $urandom_range(0, 14);
   endfunction

   function automatic logic [DATA_W-1:0] draw_value();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return ONES;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic push_request(input op_type m, input logic [KEY_W-1:0] k,
                               input logic [DATA_W-1:0] v);
      int gap;
      gap = draw_idle(src_calm);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.mode  <= m;
      req_bus.key   <= k;
      req_bus.value <= v;
      do @(posedge clock); while (!req_bus.ready);
      pending_replies.push_back(hash_apply(m, k, v));
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   task automatic set_limit(input logic [LIMIT_W-1:0] lim);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= lim;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      map_limit = lim;
   endtask

   // Most keys crowd a dozen neighboring home slots, with a few high-bit variants per slot.
   task automatic churn(input int count);
      logic [53:0]       hi [4];
      logic [63:0]       wide;
      logic [KEY_W-1:0]  k;
      op_type            m;
      int                base;
      int                pick;
      base = $urandom_range(0, CAPACITY - 1);
      foreach (hi[i]) begin
         wide  = {$urandom, $urandom};
         hi[i] = wide[63:10];
      end
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         m = pick < 40 ? OP_INSERT : pick < 70 ? OP_LOOKUP : pick < 97 ? OP_REMOVE : OP_CLEAR;
         if ($urandom_range(0, 15) == 0)
            k = {$urandom, $urandom};
         else
            k = {hi[$urandom_range(0, 3)], SLOT_BITS'(base + $urandom_range(0, 11))};
         push_request(m, k, draw_value());
      end
   endtask

   task automatic fill_homes(input int first, input int last);
      logic [63:0] wide;
      for (int i = first; i <= last; i++) begin
         wide = {$urandom, $urandom};
         wide[SLOT_BITS-1:0] = SLOT_BITS'(i);
         filled_keys.push_back(wide);
         push_request(OP_INSERT, wide, draw_value());
      end
   endtask

   task automatic mix_on_filled(input int count);
      logic [KEY_W-1:0] k;
      int               pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         k    = filled_keys[$urandom_range(0, filled_keys.size() - 1)];
         if (pick < 30)
            push_request(OP_LOOKUP, k, draw_value());
         else if (pick < 55)
            push_request(OP_INSERT, k, draw_value());
         else if (pick < 70)
            push_request(OP_REMOVE, k, draw_value());
         else if (pick < 85)
            push_request(OP_INSERT, {$urandom, $urandom}, draw_value());
         else
            push_request(OP_LOOKUP, {$urandom, $urandom}, draw_value());
      end
   endtask

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG) begin
         $display("linear_probe_hash_table_tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : reply_check
      reply_type got;
      reply_type want;
      int        stall;
      rsp_bus.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         stall = draw_idle(snk_calm);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         got.was_present  = rsp_bus.was_present;
         got.read_value   = rsp_bus.read_value;
         got.refused      = rsp_bus.refused;
         got.live_entries = rsp_bus.live_entries;
         if (pending_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("reply %0d arrived with nothing expected", replies_seen);
         end else begin
            want = pending_replies.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("reply %0d: expected present=%0b value=%h refused=%0b live=%0d",
                           replies_seen, want.was_present, want.read_value, want.refused,
                           want.live_entries);
                  $display("reply %0d: got      present=%0b value=%h refused=%0b live=%0d",
                           replies_seen, got.was_present, got.read_value, got.refused,
                           got.live_entries);
               end
            end
         end
         replies_seen++;
      end
   end

   initial begin : stimulus
      req_bus.valid = 1'b0;
      req_bus.mode  = OP_LOOKUP;
      req_bus.key   = '0;
      req_bus.value = '0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      foreach (map_status[i]) map_status[i] = SLOT_EMPTY;
      map_live  = '0;
      map_limit = LIMIT_RESET;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].is_cfg) begin
            set_limit(DIRECTED[i].value[LIMIT_W-1:0]);
         end else begin
            push_request(DIRECTED[i].mode, DIRECTED[i].key, DIRECTED[i].value);
            if (DIRECTED[i].typed)
               pending_replies[pending_replies.size() - 1] = DIRECTED[i].want;
         end
      end

      set_limit({LIMIT_W{1'b1}});
      churn(160);
      set_limit(10'd4);
      churn(160);
      set_limit(LIMIT_W'($urandom_range(5, 1022)));
      churn(160);
      set_limit('0);
      churn(40);

      set_limit(LIMIT_RESET);
      push_request(OP_CLEAR, {$urandom, $urandom}, draw_value());
      fill_homes(0, 766);
      mix_on_filled(60);
      set_limit({LIMIT_W{1'b1}});
      fill_homes(767, CAPACITY - 2);
      mix_on_filled(20);

      drain();
      repeat (TAIL) @(posedge clock);
      if (mismatches == 0 && pending_replies.size() == 0)
         $display("linear_probe_hash_table_tb OK");
      else
         $display("linear_probe_hash_table_tb NOT OK");
      $finish;
   end

endmodule
